[hdl/lisr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lisr_pkg: shared types and constants of the stereo resampler
// Sizes of the frame memory and the position, the transaction payloads,
// the register map and the control state codes.
// ---------------------------------------------------------------------------
package lisr_pkg;

  // Frame memory depth (a power of two) and position fraction bits.
  localparam int MAX_FRAMES = 4096;
  localparam int FRAC_BITS  = 16;

  // Derived widths.
  localparam int ADDR_W = $clog2(MAX_FRAMES);
  localparam int LEN_W  = $clog2(MAX_FRAMES + 1);
  localparam int POS_W  = LEN_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(LEN_W);

  // Register field widths.
  localparam int SLEN_W  = 13;
  localparam int STEP_W  = 20;
  localparam int PADDR_W = 4;
  localparam int DATA_W  = 32;

  // Reset step is 1.0 in the position's fixed-point format.
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1 << FRAC_BITS);

  // Output sample limits.
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } lisr_op_t;

  // Register indexes.
  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_LOOP   = 2'd1,
    REG_PAUSE  = 2'd2,
    REG_STEP   = 2'd3
  } lisr_reg_t;

  // Control states of the tick sequencer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MOD,
    ST_RD0,
    ST_RD1,
    ST_MUL,
    ST_FIN
  } lisr_state_t;

  // Input transaction payload.
  typedef struct packed {
    lisr_op_t           op;
    logic [11:0]        frame_addr;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } lisr_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               is_playing;
  } lisr_out_t;

  // One stereo frame as stored: right in the high half, left in the low half.
  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } lisr_frame_t;

  // Effective configuration handed to the datapath.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic              loop_en;
    logic              pause;
    logic [STEP_W-1:0] step;
  } lisr_cfg_t;

endpackage

[hdl/lisr_regs.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lisr_regs: configuration register file
// APB-style write and read of length, loop, pause and step; hands the
// clamped length and the other fields to the datapath.
// ---------------------------------------------------------------------------
module lisr_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lisr_pkg::PADDR_W-1:0] paddr,
  input  logic [lisr_pkg::DATA_W-1:0]  pwdata,
  output logic [lisr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output lisr_pkg::lisr_cfg_t          cfg
);

  logic [lisr_pkg::SLEN_W-1:0] slen_r, slen_nxt;
  logic                        loop_r, loop_nxt;
  logic                        pause_r, pause_nxt;
  logic [lisr_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        wr_en;
  lisr_pkg::lisr_reg_t         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = lisr_pkg::lisr_reg_t'(paddr[3:2]);

  // Write decode.
  always_comb begin
    slen_nxt  = slen_r;
    loop_nxt  = loop_r;
    pause_nxt = pause_r;
    step_nxt  = step_r;
    if (wr_en) begin
      unique case (reg_idx)
        lisr_pkg::REG_LENGTH: slen_nxt  = pwdata[lisr_pkg::SLEN_W-1:0];
        lisr_pkg::REG_LOOP:   loop_nxt  = pwdata[0];
        lisr_pkg::REG_PAUSE:  pause_nxt = pwdata[0];
        lisr_pkg::REG_STEP:   step_nxt  = pwdata[lisr_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slen_r  <= '0;
      loop_r  <= 1'b0;
      pause_r <= 1'b0;
      step_r  <= lisr_pkg::STEP_RESET;
    end else begin
      slen_r  <= slen_nxt;
      loop_r  <= loop_nxt;
      pause_r <= pause_nxt;
      step_r  <= step_nxt;
    end
  end

  // Read decode.
  always_comb begin
    unique case (reg_idx)
      lisr_pkg::REG_LENGTH: prdata = lisr_pkg::DATA_W'(slen_r);
      lisr_pkg::REG_LOOP:   prdata = lisr_pkg::DATA_W'(loop_r);
      lisr_pkg::REG_PAUSE:  prdata = lisr_pkg::DATA_W'(pause_r);
      lisr_pkg::REG_STEP:   prdata = lisr_pkg::DATA_W'(step_r);
      default:              prdata = '0;
    endcase
  end

  // A length beyond the memory acts as a full memory.
  always_comb begin
    cfg.loop_en = loop_r;
    cfg.pause   = pause_r;
    cfg.step    = step_r;
    if (32'(slen_r) > 32'(lisr_pkg::MAX_FRAMES)) begin
      cfg.len = lisr_pkg::LEN_W'(lisr_pkg::MAX_FRAMES);
    end else begin
      cfg.len = lisr_pkg::LEN_W'(slen_r);
    end
  end

endmodule

[hdl/lisr_frame_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lisr_frame_ram: stereo frame memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lisr_frame_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [lisr_pkg::ADDR_W-1:0] waddr,
  input  lisr_pkg::lisr_frame_t       wdata,
  input  logic [lisr_pkg::ADDR_W-1:0] raddr,
  output lisr_pkg::lisr_frame_t       rdata
);

  lisr_pkg::lisr_frame_t mem [lisr_pkg::MAX_FRAMES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/lisr_rem.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lisr_rem: frame index remainder unit
// Restoring remainder of the integer position by the length, one
// dividend bit per cycle, most significant bit first.
// ---------------------------------------------------------------------------
module lisr_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lisr_pkg::LEN_W-1:0] dividend,
  input  logic [lisr_pkg::LEN_W-1:0] divisor,
  output logic                       done,
  output logic [lisr_pkg::LEN_W-1:0] rem
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [lisr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [lisr_pkg::LEN_W-1:0] rem_r, rem_nxt;
  logic [lisr_pkg::LEN_W:0]   trial;

  assign trial = {rem_r, dividend[cnt_r]};

  // One shift and conditional subtract per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = lisr_pkg::CNT_W'(lisr_pkg::LEN_W - 1);
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = lisr_pkg::LEN_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = lisr_pkg::LEN_W'(trial);
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[hdl/lisr_lerp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lisr_lerp: one-channel linear interpolator
// Registers a*S + (b-a)*t, then truncates toward zero and saturates.
// ---------------------------------------------------------------------------
module lisr_lerp (
  input  logic                           clk,
  input  logic                           load,
  input  logic signed [15:0]             a,
  input  logic signed [15:0]             b,
  input  logic [lisr_pkg::FRAC_BITS-1:0] t,
  output logic signed [15:0]             q
);

  localparam int FB    = lisr_pkg::FRAC_BITS;
  localparam int ACC_W = FB + 18;
  localparam int Q_W   = ACC_W - FB;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(lisr_pkg::SAMPLE_MAX);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(lisr_pkg::SAMPLE_MIN);

  logic signed [16:0]      diff;
  logic signed [FB:0]      t_s;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] a_sh;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [Q_W-1:0]   q_full;
  logic                    round_up;

  // a*(S-t) + b*t written as a*S + (b-a)*t.
  assign diff    = {b[15], b} - {a[15], a};
  assign t_s     = {1'b0, t};
  assign prod    = diff * t_s;
  assign a_sh    = {{(ACC_W - 16 - FB){a[15]}}, a, {FB{1'b0}}};
  assign acc_nxt = load ? (a_sh + prod) : acc_r;

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Arithmetic shift floors; a negative value with a nonzero fraction
  // moves up by one to truncate toward zero.
  assign round_up = acc_r[ACC_W-1] && (|acc_r[FB-1:0]);
  assign q_full   = $signed(acc_r[ACC_W-1:FB]) + $signed({{(Q_W-1){1'b0}}, round_up});

  always_comb begin
    if (q_full > Q_MAX) begin
      q = 16'(Q_MAX);
    end else if (q_full < Q_MIN) begin
      q = 16'(Q_MIN);
    end else begin
      q = 16'(q_full);
    end
  end

endmodule

[hdl/linear_interp_stereo_resampler_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_interp_stereo_resampler_top: stereo linear-interpolation resampler
// Plays a stereo frame memory at a fixed-point step, one output frame per
// tick transaction, with loop or stop at the end of the sample.
//
//   Channel  Direction  Handshake                 Payload
//   in_      input      in_valid / in_ready       lisr_in_t (op, addr, samples)
//   out_     output     out_valid / out_ready     lisr_out_t (samples, playing)
//   cfg      input      psel, penable, pwrite     paddr, pwdata, prdata
//
// Write, start and stop transactions leave the sequencer idle.
// A playing tick steps through evaluate, two frame memory reads on the
// single read port, multiply, then load the output register.
// A tick that wraps the position also passes through the bit-serial
// remainder; a silent tick goes from evaluate straight to the output register.
// Reset is synchronous; the frame memory needs no clearing pass.
// A stalled result holds the sequencer in its final state until taken.
// ---------------------------------------------------------------------------
module linear_interp_stereo_resampler_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lisr_pkg::lisr_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lisr_pkg::lisr_out_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lisr_pkg::PADDR_W-1:0] paddr,
  input  logic [lisr_pkg::DATA_W-1:0]  pwdata,
  output logic [lisr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int FB     = lisr_pkg::FRAC_BITS;
  localparam int POS_W  = lisr_pkg::POS_W;
  localparam int LEN_W  = lisr_pkg::LEN_W;
  localparam int ADDR_W = lisr_pkg::ADDR_W;

  lisr_pkg::lisr_state_t state_r, state_nxt;
  lisr_pkg::lisr_cfg_t   cfg;
  lisr_pkg::lisr_frame_t wr_frame;
  lisr_pkg::lisr_frame_t rd_frame;
  lisr_pkg::lisr_frame_t a_r, a_nxt;
  lisr_pkg::lisr_out_t   out_data_r, out_data_nxt;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              playing_r, playing_nxt;
  logic              zero_r, zero_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              in_fire;
  logic              out_free;
  logic              silent;
  logic              at_end;
  logic [POS_W-1:0]  span;
  logic [LEN_W-1:0]  f0;
  logic [LEN_W-1:0]  f1_inc;
  logic [LEN_W-1:0]  f1;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic              ram_we;
  logic              rem_start;
  logic              rem_done;
  logic [LEN_W-1:0]  rem;
  logic              lerp_load;
  logic              fin_fire;
  logic signed [15:0] left_q;
  logic signed [15:0] right_q;

  // Configuration registers.
  lisr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake terms.
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Tick decision terms.
  assign silent = !playing_r || cfg.pause || (cfg.len == '0);
  assign span   = {cfg.len, {FB{1'b0}}};
  assign at_end = pos_r >= span;

  // Frame indexes; the next frame wraps or holds at the end of the sample.
  assign f0     = pos_r[POS_W-1:FB];
  assign f1_inc = f0 + 1'b1;
  always_comb begin
    if (f1_inc >= cfg.len) begin
      f1 = cfg.loop_en ? '0 : f0;
    end else begin
      f1 = f1_inc;
    end
  end

  // Frame memory; the write address wraps at the memory depth.
  assign waddr          = ADDR_W'(32'(in_data.frame_addr) % lisr_pkg::MAX_FRAMES);
  assign wr_frame.left  = in_data.left_in;
  assign wr_frame.right = in_data.right_in;
  assign ram_we         = in_fire && (in_data.op == lisr_pkg::OP_WRITE);

  lisr_frame_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wr_frame),
    .raddr (raddr),
    .rdata (rd_frame)
  );

  // Position wrap for looped playback.
  lisr_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (f0),
    .divisor  (cfg.len),
    .done     (rem_done),
    .rem      (rem)
  );

  // Interpolators for both channels.
  lisr_lerp u_lerp_left (
    .clk  (clk),
    .load (lerp_load),
    .a    (a_r.left),
    .b    (rd_frame.left),
    .t    (pos_r[FB-1:0]),
    .q    (left_q)
  );

  lisr_lerp u_lerp_right (
    .clk  (clk),
    .load (lerp_load),
    .a    (a_r.right),
    .b    (rd_frame.right),
    .t    (pos_r[FB-1:0]),
    .q    (right_q)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lisr_pkg::ST_IDLE: begin
        if (in_fire && (in_data.op == lisr_pkg::OP_TICK)) begin
          state_nxt = lisr_pkg::ST_EVAL;
        end
      end
      lisr_pkg::ST_EVAL: begin
        if (silent) begin
          state_nxt = lisr_pkg::ST_FIN;
        end else if (at_end) begin
          state_nxt = cfg.loop_en ? lisr_pkg::ST_MOD : lisr_pkg::ST_FIN;
        end else begin
          state_nxt = lisr_pkg::ST_RD0;
        end
      end
      lisr_pkg::ST_MOD: begin
        if (rem_done) begin
          state_nxt = lisr_pkg::ST_RD0;
        end
      end
      lisr_pkg::ST_RD0: state_nxt = lisr_pkg::ST_RD1;
      lisr_pkg::ST_RD1: state_nxt = lisr_pkg::ST_MUL;
      lisr_pkg::ST_MUL: state_nxt = lisr_pkg::ST_FIN;
      lisr_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = lisr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lisr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    rem_start = 1'b0;
    lerp_load = 1'b0;
    fin_fire  = 1'b0;
    raddr     = ADDR_W'(f0);
    unique case (state_r)
      lisr_pkg::ST_IDLE: in_ready = 1'b1;
      lisr_pkg::ST_EVAL: rem_start = !silent && at_end && cfg.loop_en;
      lisr_pkg::ST_MOD:  ;
      lisr_pkg::ST_RD0:  raddr = ADDR_W'(f0);
      lisr_pkg::ST_RD1:  raddr = ADDR_W'(f1);
      lisr_pkg::ST_MUL:  lerp_load = 1'b1;
      lisr_pkg::ST_FIN:  fin_fire = out_free;
      default: ;
    endcase
  end

  // Playback state and result register updates.
  always_comb begin
    pos_nxt       = pos_r;
    playing_nxt   = playing_r;
    zero_nxt      = zero_r;
    a_nxt         = a_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (in_fire) begin
      case (in_data.op)
        lisr_pkg::OP_START: playing_nxt = 1'b1;
        lisr_pkg::OP_STOP: begin
          playing_nxt = 1'b0;
          pos_nxt     = '0;
        end
        default: ;
      endcase
    end

    // Silence for an idle, paused or empty block, and at the end of a
    // sample without looping, which also stops playback.
    if (state_r == lisr_pkg::ST_EVAL) begin
      zero_nxt = silent || (at_end && !cfg.loop_en);
      if (!silent && at_end && !cfg.loop_en) begin
        playing_nxt = 1'b0;
      end
    end

    if ((state_r == lisr_pkg::ST_MOD) && rem_done) begin
      pos_nxt = {rem, pos_r[FB-1:0]};
    end

    // First frame of the pair arrives while the second is being read.
    if (state_r == lisr_pkg::ST_RD1) begin
      a_nxt = rd_frame;
    end

    if (fin_fire) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.left_out   = zero_r ? 16'sd0 : left_q;
      out_data_nxt.right_out  = zero_r ? 16'sd0 : right_q;
      out_data_nxt.is_playing = playing_r;
      if (!zero_r) begin
        pos_nxt = POS_W'(pos_r + POS_W'(cfg.step));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lisr_pkg::ST_IDLE;
      pos_r       <= '0;
      playing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      playing_r   <= playing_nxt;
      out_valid_r <= out_valid_nxt;
    end
    zero_r     <= zero_nxt;
    a_r        <= a_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // The frame read always starts inside the sample.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lisr_pkg::ST_RD0) |-> (pos_r[POS_W-1:FB] < cfg.len))
    else $error("frame read starts beyond the sample length");

  // Only a tick transaction occupies the sequencer.
  a_non_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.op != lisr_pkg::OP_TICK)) |=> (state_r == lisr_pkg::ST_IDLE))
    else $error("non-tick transaction left the sequencer busy");

  // The remainder unit finishes only while the sequencer waits for it.
  a_rem_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == lisr_pkg::ST_MOD))
    else $error("remainder completed outside the wrap state");

  // Playback stops only on a stop transaction or at the end of the sample.
  a_playing_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(playing_r) |->
      ($past(in_fire && (in_data.op == lisr_pkg::OP_STOP)) ||
       $past(state_r == lisr_pkg::ST_EVAL)))
    else $error("playing cleared without a stop or end of sample");
`endif

endmodule

[sim/linear_interp_stereo_resampler_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_interp_stereo_resampler_top_tb: self-checking bench of the resampler
// A short table of directed transactions is run first, followed by phases of
// random traffic under changing register settings and handshake pressure.
// Every result transaction is checked, field by field, against a fixed table
// value or a behavioral predictor of frame memory, play position and playing flag.
// ---------------------------------------------------------------------------
module linear_interp_stereo_resampler_top_tb;
  import lisr_pkg::*;

  // Row kinds of the directed table.
  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    lisr_in_t    item;
    logic        fixed;
    lisr_out_t   result;
    lisr_reg_t   reg_idx;
    logic [31:0] value;
  } stim_row_t;

  localparam int RANDOM_PHASES    = 16;
  localparam int ITEMS_PER_PHASE  = 125;
  localparam int LONG_LEN_PHASE   = 8;
  localparam int SETTLE_CYCLES    = 40;
  localparam int PREFIX_SOFT_MAX  = 64;

  // Clock, reset and ports.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lisr_in_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lisr_out_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Predictor state and register copies.
  lisr_frame_t         frame_mem [MAX_FRAMES];
  bit                  frame_loaded [MAX_FRAMES];
  int                  loaded_prefix = 0;
  longint unsigned     play_pos = 0;
  bit                  playing = 1'b0;
  logic [SLEN_W-1:0]   cfg_len = '0;
  logic                cfg_loop = 1'b0;
  logic                cfg_pause = 1'b0;
  logic [STEP_W-1:0]   cfg_step = STEP_RESET;

  // Expected output frames, oldest first, and checking state.
  lisr_out_t           pending_frames [$];
  int                  mismatch_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  stim_row_t           directed_rows [$];

  linear_interp_stereo_resampler_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Free-running 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn at every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Linear blend of two samples, truncated toward zero and saturated.
  function automatic logic signed [15:0] blend(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic [FRAC_BITS-1:0] frac);
    longint scale;
    longint acc;
    longint q;
    scale = longint'(1) << FRAC_BITS;
    acc = longint'(a) * (scale - longint'(frac)) + longint'(b) * longint'(frac);
    q = acc / scale;
    if (q < SAMPLE_MIN) q = SAMPLE_MIN;
    if (q > SAMPLE_MAX) q = SAMPLE_MAX;
    return q[15:0];
  endfunction

  // True when a tick accepted now would read a frame that was never written.
  function automatic bit tick_reads_unwritten();
    longint unsigned len_q;
    longint unsigned span_q;
    longint unsigned pos_q;
    longint unsigned f0;
    longint unsigned f1;
    len_q = (cfg_len > MAX_FRAMES) ? longint'(MAX_FRAMES) : longint'(cfg_len);
    if (!playing || cfg_pause || len_q == 0) return 1'b0;
    span_q = len_q << FRAC_BITS;
    pos_q = play_pos;
    if (pos_q >= span_q) begin
      if (!cfg_loop) return 1'b0;
      pos_q = pos_q % span_q;
    end
    f0 = pos_q >> FRAC_BITS;
    f1 = f0 + 1;
    if (f1 >= len_q) f1 = cfg_loop ? 0 : f0;
    return !frame_loaded[ADDR_W'(f0)] || !frame_loaded[ADDR_W'(f1)];
  endfunction

  // Applies one accepted input transaction to the predictor state.
  task automatic predict_output_frame(input lisr_in_t x, output bit has_res,
                                      output lisr_out_t res);
    longint unsigned len_q;
    longint unsigned span_q;
    int              f0;
    int              f1;
    logic [FRAC_BITS-1:0] frac;
    logic [ADDR_W-1:0]    waddr;
    has_res = 1'b0;
    res = '0;
    case (x.op)
      OP_WRITE: begin
        waddr = ADDR_W'(32'(x.frame_addr) % MAX_FRAMES);
        frame_mem[waddr].left  = x.left_in;
        frame_mem[waddr].right = x.right_in;
        frame_loaded[waddr] = 1'b1;
        while (loaded_prefix < MAX_FRAMES && frame_loaded[ADDR_W'(loaded_prefix)])
          loaded_prefix++;
      end
      OP_START: playing = 1'b1;
      OP_STOP: begin
        playing = 1'b0;
        play_pos = 0;
      end
      default: begin
        has_res = 1'b1;
        len_q = (cfg_len > MAX_FRAMES) ? longint'(MAX_FRAMES) : longint'(cfg_len);
        if (!playing || cfg_pause || len_q == 0) begin
          // Silent tick: nothing moves.
          res.is_playing = playing;
        end else begin
          span_q = len_q << FRAC_BITS;
          if (play_pos >= span_q && cfg_loop) play_pos = play_pos % span_q;
          if (play_pos >= span_q) begin
            // End of sample without looping.
            playing = 1'b0;
            res.is_playing = 1'b0;
          end else begin
            f0 = int'(play_pos >> FRAC_BITS);
            frac = play_pos[FRAC_BITS-1:0];
            f1 = f0 + 1;
            if (f1 >= len_q) f1 = cfg_loop ? 0 : f0;
            res.left_out  = blend(frame_mem[ADDR_W'(f0)].left,
                                  frame_mem[ADDR_W'(f1)].left, frac);
            res.right_out = blend(frame_mem[ADDR_W'(f0)].right,
                                  frame_mem[ADDR_W'(f1)].right, frac);
            res.is_playing = 1'b1;
            play_pos += longint'(cfg_step);
          end
        end
      end
    endcase
  endtask

  function automatic lisr_in_t mk_item(input lisr_op_t op, input logic [11:0] addr,
                                       input logic [15:0] l, input logic [15:0] r);
    lisr_in_t x;
    x.op = op;
    x.frame_addr = addr;
    x.left_in = l;
    x.right_in = r;
    return x;
  endfunction

  function automatic lisr_out_t mk_result(input logic [15:0] l, input logic [15:0] r,
                                          input logic p);
    lisr_out_t y;
    y.left_out = l;
    y.right_out = r;
    y.is_playing = p;
    return y;
  endfunction

  // Sample values with the extremes drawn often.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_item_row(input lisr_in_t x, input logic fixed, input lisr_out_t y);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item = x;
    row.fixed = fixed;
    row.result = y;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg_row(input lisr_reg_t idx, input logic [31:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.value = value;
    directed_rows.push_back(row);
  endtask

  // Sends one input transaction; called and returning at a falling edge.
  task automatic send_item(input lisr_in_t x, input logic fixed, input lisr_out_t fixed_res);
    bit        has_res;
    lisr_out_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_output_frame(x, has_res, res);
    if (has_res) pending_frames.push_back(fixed ? fixed_res : res);
    @(negedge clk);
  endtask

  // Register write over the APB port once the block has gone quiet.
  task automatic write_register(input lisr_reg_t idx, input logic [31:0] value);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_LENGTH: cfg_len = value[SLEN_W-1:0];
      REG_LOOP:   cfg_loop = value[0];
      REG_PAUSE:  cfg_pause = value[0];
      default:    cfg_step = value[STEP_W-1:0];
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Handshake pressure of one phase.
  task automatic set_pressure(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  // Result checker: each accepted output transaction against the oldest prediction.
  always @(posedge clk) begin
    lisr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
      end else begin
        want = pending_frames.pop_front();
        if (out_data !== want) begin
          mismatch_count++;
          if (out_data.left_out !== want.left_out)
            $display("%0t: left_out expected %0d actual %0d", $time,
                     want.left_out, out_data.left_out);
          if (out_data.right_out !== want.right_out)
            $display("%0t: right_out expected %0d actual %0d", $time,
                     want.right_out, out_data.right_out);
          if (out_data.is_playing !== want.is_playing)
            $display("%0t: is_playing expected %b actual %b", $time,
                     want.is_playing, out_data.is_playing);
        end
      end
    end
  end

  // Main stimulus sequence.
  initial begin
    lisr_in_t x;
    int       len_pick;
    int       step_pick;
    int       n;
    int       r;

    // Directed table: silence after reset, the frame extremes, pause, stop at
    // the end, wrap by remainder, start while playing and stop while idle.
    add_item_row(mk_item(OP_TICK, 12'hFFF, 16'hFFFF, 16'hFFFF), 1'b1,
                 mk_result(16'h0000, 16'h0000, 1'b0));
    add_item_row(mk_item(OP_STOP, 12'h000, 16'h0000, 16'h0000), 1'b0, '0);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b1,
                 mk_result(16'h0000, 16'h0000, 1'b0));
    add_item_row(mk_item(OP_WRITE, 12'd0, 16'h7FFF, 16'h8000), 1'b0, '0);
    add_item_row(mk_item(OP_WRITE, 12'd1, 16'h8000, 16'h7FFF), 1'b0, '0);
    add_item_row(mk_item(OP_WRITE, 12'd2, 16'hFFFF, 16'h0001), 1'b0, '0);
    add_item_row(mk_item(OP_WRITE, 12'd3, 16'h1234, 16'hEDCC), 1'b0, '0);
    add_item_row(mk_item(OP_WRITE, 12'hFFF, 16'h5555, 16'hAAAA), 1'b0, '0);
    add_item_row(mk_item(OP_START, 12'h000, 16'h0000, 16'h0000), 1'b0, '0);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b1,
                 mk_result(16'h0000, 16'h0000, 1'b1));
    add_cfg_row(REG_LENGTH, 32'd4);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b1,
                 mk_result(16'h7FFF, 16'h8000, 1'b1));
    add_cfg_row(REG_STEP, 32'h8000);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b1,
                 mk_result(16'h8000, 16'h7FFF, 1'b1));
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b0, '0);
    add_item_row(mk_item(OP_START, 12'hABC, 16'h1111, 16'h2222), 1'b0, '0);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b0, '0);
    add_cfg_row(REG_PAUSE, 32'd1);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b1,
                 mk_result(16'h0000, 16'h0000, 1'b1));
    add_cfg_row(REG_PAUSE, 32'd0);
    add_cfg_row(REG_STEP, 32'hFFFFF);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b0, '0);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b1,
                 mk_result(16'h0000, 16'h0000, 1'b0));
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b1,
                 mk_result(16'h0000, 16'h0000, 1'b0));
    add_cfg_row(REG_LOOP, 32'd1);
    add_item_row(mk_item(OP_START, 12'h000, 16'h0000, 16'h0000), 1'b0, '0);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b0, '0);
    add_cfg_row(REG_STEP, 32'd0);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b0, '0);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b0, '0);
    add_item_row(mk_item(OP_STOP, 12'h000, 16'h0000, 16'h0000), 1'b0, '0);
    add_item_row(mk_item(OP_TICK, 12'h000, 16'h0000, 16'h0000), 1'b1,
                 mk_result(16'h0000, 16'h0000, 1'b0));

    // Reset, released on a falling edge.
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_register(directed_rows[i].reg_idx, directed_rows[i].value);
      else
        send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].result);
    end

    // Random phases. A tick that would read a frame never written is sent
    // as a stop instead, which rewinds the position into the written prefix.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_pressure(phase);

      // Grow the written prefix a little.
      if (loaded_prefix < PREFIX_SOFT_MAX) begin
        n = $urandom_range(1, 12);
        repeat (n)
          send_item(mk_item(OP_WRITE, 12'(loaded_prefix), pick_sample(), pick_sample()),
                    1'b0, '0);
      end

      // Register settings of this phase, extremes included.
      r = $urandom_range(0, 9);
      if (phase == LONG_LEN_PHASE) len_pick = (1 << SLEN_W) - 1;
      else if (phase == LONG_LEN_PHASE + 1) len_pick = MAX_FRAMES;
      else if (r == 0) len_pick = 0;
      else if (r == 1) len_pick = 1;
      else if (r <= 3) len_pick = loaded_prefix;
      else len_pick = $urandom_range(1, loaded_prefix);

      case ($urandom_range(0, 9))
        0: step_pick = 0;
        1: step_pick = (1 << STEP_W) - 1;
        2: step_pick = 1;
        3, 4, 5, 6: step_pick = $urandom_range(0, 3 << FRAC_BITS);
        default: step_pick = $urandom_range(0, (1 << STEP_W) - 1);
      endcase

      write_register(REG_LENGTH, 32'(len_pick));
      write_register(REG_LOOP, 32'($urandom_range(0, 1)));
      write_register(REG_PAUSE, 32'($urandom_range(0, 7) == 0));
      write_register(REG_STEP, 32'(step_pick));

      // Start playback, then mostly ticks with writes, starts and stops mixed in.
      send_item(mk_item(OP_START, 12'($urandom), 16'($urandom), 16'($urandom)), 1'b0, '0);
      repeat (ITEMS_PER_PHASE) begin
        x = mk_item(OP_TICK, 12'($urandom), 16'($urandom), 16'($urandom));
        r = $urandom_range(0, 99);
        if (r < 65) x.op = OP_TICK;
        else if (r < 80) begin
          x.op = OP_WRITE;
          x.left_in = pick_sample();
          x.right_in = pick_sample();
        end else if (r < 90) x.op = OP_START;
        else x.op = OP_STOP;
        if (x.op == OP_TICK && tick_reads_unwritten()) x.op = OP_STOP;
        send_item(x, 1'b0, '0);
      end
    end

    // Drain, let the block settle, then report.
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("linear_interp_stereo_resampler_top: match");
    end else begin
      $display("linear_interp_stereo_resampler_top: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("linear_interp_stereo_resampler_top: mismatch");
    $finish;
  end

endmodule

[linear_interp_stereo_resampler_top.f]
hdl/lisr_pkg.sv
hdl/lisr_regs.sv
hdl/lisr_frame_ram.sv
hdl/lisr_rem.sv
hdl/lisr_lerp.sv
hdl/linear_interp_stereo_resampler_top.sv
sim/linear_interp_stereo_resampler_top_tb.sv
